[design/ibrp_pkg.sv]
// package for the index broadcast record parser
// holds the result record type, header/record layout constants and register codes
// no dependencies
`timescale 1ns / 1ps

package ibrp_pkg;

    // default sizing
    localparam int MAX_RECORDS_DEF        = 24;
    localparam int MAX_DATAGRAM_BYTES_DEF = 2000;

    // configuration registers
    localparam int          CFG_IDX_W    = 2;
    localparam logic [31:0] TYPE_ONE_RST = 32'd2011;
    localparam logic [31:0] TYPE_TWO_RST = 32'd2012;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TYPE_ONE = 2'd0,
        CFG_TYPE_TWO = 2'd1
    } t_cfg_idx;

    // header layout, byte offsets in the datagram
    localparam int TYPE_BYTES     = 4;
    localparam int TYPE_LAST_OFF  = 3;
    localparam int TIME_FIRST_OFF = 14;
    localparam int TIME_END_OFF   = 22;
    localparam int CNT_HI_OFF     = 26;
    localparam int CNT_LO_OFF     = 27;
    localparam int HDR_BYTES      = 28;

    // record layout, byte positions within one record
    localparam int REC_BYTES     = 40;
    localparam int REC_POS_W     = 6;
    localparam int REC_VAL_BYTES = 24;
    localparam int IND_HI_POS    = 36;
    localparam int IND_LO_POS    = 37;
    localparam int NUM_VALS      = 6;

    typedef struct packed {
        logic               status;
        logic               type_two_flag;
        logic [63:0]        time_stamp;
        logic [4:0]         record_number;
        logic [31:0]        idx_code;
        logic [31:0]        day_high;
        logic [31:0]        day_low;
        logic [31:0]        day_open;
        logic [31:0]        previous_close;
        logic [31:0]        current_value;
        logic signed [15:0] close_indicator;
        logic               last_of_message;
    } t_result;

endpackage

[design/ibrp_parser.sv]
// byte parser: header decode, record assembly and result generation
// one byte is consumed per transfer; depends on ibrp_pkg
`timescale 1ns / 1ps

module ibrp_parser #(
    parameter int MAX_RECORDS        = ibrp_pkg::MAX_RECORDS_DEF,
    parameter int MAX_DATAGRAM_BYTES = ibrp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end,
    input  logic [31:0]       i_type_one,
    input  logic [31:0]       i_type_two,
    output logic              o_res_valid,
    output ibrp_pkg::t_result o_res
);
    import ibrp_pkg::*;

    localparam int OFF_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int RC_W  = $clog2(MAX_RECORDS + 1);

    logic [OFF_W-1:0]     r_off, n_off;
    logic [31:0]          r_type, n_type;
    logic                 r_drop, n_drop;
    logic [63:0]          r_time, n_time;
    logic [RC_W-1:0]      r_declared, n_declared;
    logic [RC_W-1:0]      r_emitted, n_emitted;
    logic [31:0]          r_vals [NUM_VALS];
    logic [31:0]          n_vals [NUM_VALS];
    logic [7:0]           r_hi, n_hi;
    logic [REC_POS_W-1:0] r_pos, n_pos;

    logic        live;
    logic        emit;
    logic        final_rec;
    logic [15:0] cnt;
    logic [15:0] ind;

    always_comb begin
        n_off      = r_off;
        n_type     = r_type;
        n_drop     = r_drop;
        n_time     = r_time;
        n_declared = r_declared;
        n_emitted  = r_emitted;
        n_hi       = r_hi;
        n_pos      = r_pos;
        for (int j = 0; j < NUM_VALS; j++) begin
            n_vals[j] = r_vals[j];
        end
        emit      = 1'b0;
        final_rec = 1'b0;
        cnt       = {r_hi, i_data_byte};
        ind       = {r_hi, i_data_byte};
        live      = r_off < OFF_W'(MAX_DATAGRAM_BYTES);

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            if (live && !r_drop) begin
                if (r_off < OFF_W'(TYPE_BYTES)) begin
                    n_type = {r_type[23:0], i_data_byte};
                    if (r_off == OFF_W'(TYPE_LAST_OFF) && n_type != i_type_one &&
                        n_type != i_type_two) begin
                        n_drop = 1'b1;
                    end
                end else if (r_off >= OFF_W'(TIME_FIRST_OFF) &&
                             r_off < OFF_W'(TIME_END_OFF)) begin
                    n_time = {r_time[55:0], i_data_byte};
                end else if (r_off == OFF_W'(CNT_HI_OFF)) begin
                    n_hi = i_data_byte;
                end else if (r_off == OFF_W'(CNT_LO_OFF)) begin
                    // negative count means none, large count is clamped
                    if (cnt[15]) begin
                        n_declared = '0;
                    end else if (cnt > 16'(MAX_RECORDS)) begin
                        n_declared = RC_W'(MAX_RECORDS);
                    end else begin
                        n_declared = RC_W'(cnt);
                    end
                    n_hi = '0;
                end else if (r_off >= OFF_W'(HDR_BYTES) && r_emitted < r_declared) begin
                    if (r_pos < REC_POS_W'(REC_VAL_BYTES)) begin
                        n_vals[r_pos[4:2]] = {r_vals[r_pos[4:2]][23:0], i_data_byte};
                    end else if (r_pos == REC_POS_W'(IND_HI_POS)) begin
                        n_hi = i_data_byte;
                    end else if (r_pos == REC_POS_W'(IND_LO_POS)) begin
                        emit      = 1'b1;
                        final_rec = ((RC_W+1)'(r_emitted) + 1'b1) == {1'b0, r_declared};
                        n_emitted = r_emitted + 1'b1;
                        n_hi      = '0;
                        for (int j = 0; j < NUM_VALS; j++) begin
                            n_vals[j] = '0;
                        end
                    end
                end
            end

            // byte position inside the current record
            if (live && r_off >= OFF_W'(HDR_BYTES)) begin
                n_pos = (r_pos == REC_POS_W'(REC_BYTES - 1)) ? '0 : r_pos + 1'b1;
            end
            if (live) begin
                n_off = r_off + 1'b1;
            end

            o_res.type_two_flag = (n_type == i_type_two);
            o_res.time_stamp    = n_time;
            o_res.record_number = 5'(r_emitted);

            if (emit) begin
                o_res_valid           = 1'b1;
                o_res.status          = !final_rec && i_end;
                o_res.last_of_message = final_rec || i_end;
                o_res.idx_code        = r_vals[0];
                o_res.day_high        = r_vals[1];
                o_res.day_low         = r_vals[2];
                o_res.day_open        = r_vals[3];
                o_res.previous_close  = r_vals[4];
                o_res.current_value   = r_vals[5];
                o_res.close_indicator = ind;
            end else if (i_end && !n_drop && r_emitted < n_declared) begin
                // message ended short of its declared records
                o_res_valid           = 1'b1;
                o_res.status          = 1'b1;
                o_res.last_of_message = 1'b1;
            end

            if (i_end) begin
                n_off      = '0;
                n_type     = '0;
                n_drop     = 1'b0;
                n_time     = '0;
                n_declared = '0;
                n_emitted  = '0;
                n_hi       = '0;
                n_pos      = '0;
                for (int j = 0; j < NUM_VALS; j++) begin
                    n_vals[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_type     <= '0;
            r_drop     <= 1'b0;
            r_time     <= '0;
            r_declared <= '0;
            r_emitted  <= '0;
            r_hi       <= '0;
            r_pos      <= '0;
            for (int j = 0; j < NUM_VALS; j++) begin
                r_vals[j] <= '0;
            end
        end else begin
            r_off      <= n_off;
            r_type     <= n_type;
            r_drop     <= n_drop;
            r_time     <= n_time;
            r_declared <= n_declared;
            r_emitted  <= n_emitted;
            r_hi       <= n_hi;
            r_pos      <= n_pos;
            for (int j = 0; j < NUM_VALS; j++) begin
                r_vals[j] <= n_vals[j];
            end
        end
    end

endmodule

[design/ibrp_out_buf.sv]
// two-entry result buffer: output register plus skid register
// keeps results in order while the sink stalls; depends on ibrp_pkg
`timescale 1ns / 1ps

module ibrp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ibrp_pkg::t_result i_push_data,
    output logic              o_push_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output ibrp_pkg::t_result o_data
);
    import ibrp_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    drain;

    assign drain        = !r_out_valid || i_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (drain) begin
            // skid entry is older than a new push
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = i_push_data;
                n_skid_valid = i_push;
            end else begin
                n_out       = i_push_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_push_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

[design/index_broadcast_record_parser_core.sv]
// top level of the index broadcast record parser
// holds the type registers and joins ibrp_parser and ibrp_out_buf; depends on ibrp_pkg
//
//  channel   signals                                   direction
//  input     i_in_valid / o_in_ready, byte + end mark   sink
//  result    o_out_valid / i_out_ready, record fields   source
//  config    i_cfg_valid / o_cfg_ready, index + data    sink
//
// one byte per cycle while o_in_ready is high: each byte is parsed in the cycle it is transferred and any
// result is registered on that same edge
// a two-entry output buffer absorbs sink stalls and o_in_ready drops only while
// both entries are full
// synchronous active-low reset clears the message state and loads the type registers
// config writes are always ready and take effect on the next byte
`timescale 1ns / 1ps

module index_broadcast_record_parser_core #(
    parameter int MAX_RECORDS        = ibrp_pkg::MAX_RECORDS_DEF,
    parameter int MAX_DATAGRAM_BYTES = ibrp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_datagram,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic                          o_type_two_flag,
    output logic [63:0]                   o_time_stamp,
    output logic [4:0]                    o_record_number,
    output logic [31:0]                   o_idx_code,
    output logic [31:0]                   o_day_high,
    output logic [31:0]                   o_day_low,
    output logic [31:0]                   o_day_open,
    output logic [31:0]                   o_previous_close,
    output logic [31:0]                   o_current_value,
    output logic signed [15:0]            o_close_indicator,
    output logic                          o_last_of_message,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ibrp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import ibrp_pkg::*;

    logic [31:0] r_type_one;
    logic [31:0] r_type_two;
    logic        in_accept;
    logic        res_valid;
    t_result     res;
    t_result     out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_one <= TYPE_ONE_RST;
            r_type_two <= TYPE_TWO_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TYPE_ONE: r_type_one <= i_cfg_data;
                CFG_TYPE_TWO: r_type_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_accept = i_in_valid && o_in_ready;

    ibrp_parser #(
        .MAX_RECORDS        (MAX_RECORDS),
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_end       (i_end_of_datagram),
        .i_type_one  (r_type_one),
        .i_type_two  (r_type_two),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ibrp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_push_data  (res),
        .o_push_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (out_data)
    );

    assign o_status          = out_data.status;
    assign o_type_two_flag   = out_data.type_two_flag;
    assign o_time_stamp      = out_data.time_stamp;
    assign o_record_number   = out_data.record_number;
    assign o_idx_code        = out_data.idx_code;
    assign o_day_high        = out_data.day_high;
    assign o_day_low         = out_data.day_low;
    assign o_day_open        = out_data.day_open;
    assign o_previous_close  = out_data.previous_close;
    assign o_current_value   = out_data.current_value;
    assign o_close_indicator = out_data.close_indicator;
    assign o_last_of_message = out_data.last_of_message;

`ifndef ASSERT_OFF
    // a truncated result always closes its message
    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_last_of_message)
        else $error("truncated result without last mark");

    // record numbers stay below the clamp
    a_rec_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_record_number < 5'(MAX_RECORDS))
        else $error("record number out of range");

    // input backpressure only with a full output buffer
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // parser never pushes into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> in_accept)
        else $error("result produced without a byte transfer");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for index_broadcast_record_parser_core
// streams datagrams byte by byte and checks every record result against a scoreboard
// depends on ibrp_pkg and the core
`timescale 1ns / 1ps

module testbench;

    import ibrp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_BYTES   = 450;
    localparam int QUIET_BYTES  = 340;
    localparam int LIMIT        = 400000;

    // parses the byte stream the same way the core does and queues the records it owes
    class record_scoreboard;
        t_result     expected_records[$];
        int          errors;
        logic [31:0] type_one;
        logic [31:0] type_two;
        int          offset;
        logic [31:0] hdr_type;
        bit          dropping;
        logic [63:0] stamp;
        int          declared;
        int          emitted;
        logic [31:0] vals [NUM_VALS];
        logic [7:0]  hi_byte;

        function new();
            errors       = 0;
            type_one     = TYPE_ONE_RST;
            type_two     = TYPE_TWO_RST;
            clear_message();
        endfunction

        function void clear_message();
            offset   = 0;
            hdr_type = '0;
            dropping = 1'b0;
            stamp    = '0;
            declared = 0;
            emitted  = 0;
            foreach (vals[k]) vals[k] = '0;
            hi_byte  = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_TYPE_ONE: type_one = value;
                CFG_TYPE_TWO: type_two = value;
                default: ;
            endcase
        endfunction

        function t_result make_result(bit status, bit with_rec, logic [15:0] ind, bit last);
            t_result r;
            r.status          = status;
            r.type_two_flag   = (hdr_type == type_two);
            r.time_stamp      = stamp;
            r.record_number   = 5'(emitted);
            r.idx_code        = with_rec ? vals[0] : '0;
            r.day_high        = with_rec ? vals[1] : '0;
            r.day_low         = with_rec ? vals[2] : '0;
            r.day_open        = with_rec ? vals[3] : '0;
            r.previous_close  = with_rec ? vals[4] : '0;
            r.current_value   = with_rec ? vals[5] : '0;
            r.close_indicator = with_rec ? ind : '0;
            r.last_of_message = last;
            return r;
        endfunction

        function void parse_byte(logic [7:0] b, logic eom);
            t_result     r;
            bit          have;
            bit          last_rec;
            int          pos;
            logic [15:0] cnt;
            logic [15:0] ind;
            have = 1'b0;
            if (offset < MAX_DATAGRAM_BYTES_DEF && !dropping) begin
                if (offset < TYPE_BYTES) begin
                    hdr_type = {hdr_type[23:0], b};
                    if (offset == TYPE_LAST_OFF && hdr_type != type_one && hdr_type != type_two)
                        dropping = 1'b1;
                end else if (offset >= TIME_FIRST_OFF && offset < TIME_END_OFF) begin
                    stamp = {stamp[55:0], b};
                end else if (offset == CNT_HI_OFF) begin
                    hi_byte = b;
                end else if (offset == CNT_LO_OFF) begin
                    cnt = {hi_byte, b};
                    if (cnt[15])
                        declared = 0;
                    else if (int'(cnt) > MAX_RECORDS_DEF)
                        declared = MAX_RECORDS_DEF;
                    else
                        declared = int'(cnt);
                    hi_byte = '0;
                end else if (offset >= HDR_BYTES && emitted < declared) begin
                    pos = (offset - HDR_BYTES) % REC_BYTES;
                    if (pos < REC_VAL_BYTES) begin
                        vals[pos / 4] = {vals[pos / 4][23:0], b};
                    end else if (pos == IND_HI_POS) begin
                        hi_byte = b;
                    end else if (pos == IND_LO_POS) begin
                        ind      = {hi_byte, b};
                        last_rec = (emitted + 1 == declared);
                        // a record finishing on the end mark with more declared is truncated
                        r        = make_result(!last_rec && eom, 1'b1, ind, last_rec || eom);
                        have     = 1'b1;
                        emitted  = (emitted + 1) & 31;
                        foreach (vals[k]) vals[k] = '0;
                        hi_byte  = '0;
                    end
                end
            end
            if (offset < MAX_DATAGRAM_BYTES_DEF)
                offset = offset + 1;
            if (eom) begin
                if (!have && !dropping && emitted < declared) begin
                    r    = make_result(1'b1, 1'b0, '0, 1'b1);
                    have = 1'b1;
                end
                clear_message();
            end
            if (have)
                expected_records.insert(expected_records.size(), r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want, int rec);
            if (got !== want)
                report_mismatch($sformatf("record %0d %s got %h expected %h",
                                          rec, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            int      rec;
            if (expected_records.size() == 0) begin
                report_mismatch($sformatf("result with no expectation, record %0d",
                                          got.record_number));
                return;
            end
            want = expected_records.pop_front();
            rec  = int'(want.record_number);
            compare_field("status", 64'(got.status), 64'(want.status), rec);
            compare_field("type_two_flag", 64'(got.type_two_flag),
                          64'(want.type_two_flag), rec);
            compare_field("time_stamp", got.time_stamp, want.time_stamp, rec);
            compare_field("record_number", 64'(got.record_number),
                          64'(want.record_number), rec);
            compare_field("idx_code", 64'(got.idx_code), 64'(want.idx_code), rec);
            compare_field("day_high", 64'(got.day_high), 64'(want.day_high), rec);
            compare_field("day_low", 64'(got.day_low), 64'(want.day_low), rec);
            compare_field("day_open", 64'(got.day_open), 64'(want.day_open), rec);
            compare_field("previous_close", 64'(got.previous_close),
                          64'(want.previous_close), rec);
            compare_field("current_value", 64'(got.current_value),
                          64'(want.current_value), rec);
            compare_field("close_indicator", 64'(got.close_indicator),
                          64'(want.close_indicator), rec);
            compare_field("last_of_message", 64'(got.last_of_message),
                          64'(want.last_of_message), rec);
        endtask
    endclass

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte       = '0;
    logic                 i_end_of_datagram = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready       = 1'b0;
    logic                 o_status;
    logic                 o_type_two_flag;
    logic [63:0]          o_time_stamp;
    logic [4:0]           o_record_number;
    logic [31:0]          o_idx_code;
    logic [31:0]          o_day_high;
    logic [31:0]          o_day_low;
    logic [31:0]          o_day_open;
    logic [31:0]          o_previous_close;
    logic [31:0]          o_current_value;
    logic signed [15:0]   o_close_indicator;
    logic                 o_last_of_message;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index       = '0;
    logic [31:0]          i_cfg_data        = '0;

    record_scoreboard board;
    bit  idle_on      = 1'b1;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    int  stall_left   = 0;
    int  sent_bytes   = 0;
    int  cycle_count  = 0;

    index_broadcast_record_parser_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_type_two_flag   (o_type_two_flag),
        .o_time_stamp      (o_time_stamp),
        .o_record_number   (o_record_number),
        .o_idx_code        (o_idx_code),
        .o_day_high        (o_day_high),
        .o_day_low         (o_day_low),
        .o_day_open        (o_day_open),
        .o_previous_close  (o_previous_close),
        .o_current_value   (o_current_value),
        .o_close_indicator (o_close_indicator),
        .o_last_of_message (o_last_of_message),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("[index_broadcast_record_parser_core] ERROR");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin : result_sink
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status          = o_status;
            got.type_two_flag   = o_type_two_flag;
            got.time_stamp      = o_time_stamp;
            got.record_number   = o_record_number;
            got.idx_code        = o_idx_code;
            got.day_high        = o_day_high;
            got.day_low         = o_day_low;
            got.day_open        = o_day_open;
            got.previous_close  = o_previous_close;
            got.current_value   = o_current_value;
            got.close_indicator = o_close_indicator;
            got.last_of_message = o_last_of_message;
            board.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request) begin
            // long hold so the output buffer fills and the input stalls
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic eom);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_data_byte       <= b;
        i_end_of_datagram <= eom;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.parse_byte(b, eom);
        sent_bytes++;
    endtask

    // fill < 0 gives random bytes outside the type and count fields
    task automatic send_message(input logic [31:0] mtype, input logic [15:0] cnt,
                                input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i < TYPE_BYTES)
                b = mtype[8 * (TYPE_BYTES - 1 - i) +: 8];
            else if (i == CNT_HI_OFF)
                b = cnt[15:8];
            else if (i == CNT_LO_OFF)
                b = cnt[7:0];
            else if (fill < 0)
                b = 8'($urandom_range(0, 255));
            else
                b = 8'(fill);
            put_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_types(input logic [31:0] one, input logic [31:0] two);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TYPE_ONE;
        i_cfg_data  <= one;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(CFG_TYPE_ONE, one);
        i_cfg_index <= CFG_TYPE_TWO;
        i_cfg_data  <= two;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(CFG_TYPE_TWO, two);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_type_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return '0;
        else if (pick < 40)
            return '1;
        else if (pick < 70)
            return 32'(2000 + $urandom_range(0, 20));
        return $urandom;
    endfunction

    task automatic random_config();
        logic [31:0] one;
        logic [31:0] two;
        one = pick_type_value();
        two = ($urandom_range(0, 4) == 0) ? one : pick_type_value();
        wait_idle();
        write_types(one, two);
    endtask

    task automatic random_message();
        int          pick;
        int          n;
        int          len;
        int          full;
        logic [31:0] mtype;
        logic [15:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            mtype = board.type_one;
        else if (pick < 85)
            mtype = board.type_two;
        else
            mtype = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            cnt = 16'($urandom_range(1, 4));
        else if (pick < 72)
            cnt = '0;
        else if (pick < 80)
            cnt = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        else if (pick < 88)
            cnt = 16'($urandom_range(MAX_RECORDS_DEF + 1, 16'h7FFF));
        else if (pick < 91)
            cnt = 16'(MAX_RECORDS_DEF);
        else
            cnt = 16'($urandom_range(5, 12));
        n    = cnt[15] ? 0 : ((int'(cnt) > MAX_RECORDS_DEF) ? MAX_RECORDS_DEF : int'(cnt));
        full = HDR_BYTES + REC_BYTES * n;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            len = full;
        end else if (pick < 70) begin
            len = full + $urandom_range(1, 20);
        end else if (pick < 82) begin
            len = $urandom_range(1, full);
        end else if (pick < 92) begin
            len = (n > 0) ? HDR_BYTES + REC_BYTES * $urandom_range(0, n - 1) + IND_LO_POS + 1
                          : full;
        end else begin
            // noise
            mtype = $urandom;
            cnt   = 16'($urandom);
            len   = $urandom_range(1, 60);
        end
        // keep most full-size messages short so the run stays compact
        if (n == MAX_RECORDS_DEF && len > HDR_BYTES + 3 * REC_BYTES && $urandom_range(0, 3) != 0)
            len = $urandom_range(HDR_BYTES, HDR_BYTES + 3 * REC_BYTES + 20);
        send_message(mtype, cnt, len, -1);
    endtask

    initial begin : main
        int msg_count;
        int rand_start;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed messages under the reset types
        send_message(TYPE_ONE_RST, 16'd1, HDR_BYTES + REC_BYTES, 8'hFF);
        send_message(TYPE_TWO_RST, 16'd2, HDR_BYTES + 2 * REC_BYTES, 8'h00);
        send_message(TYPE_ONE_RST, 16'h8000, 40, -1);              // negative count
        send_message(TYPE_TWO_RST, 16'hFFFF, HDR_BYTES, -1);
        send_message(TYPE_ONE_RST, 16'd0, HDR_BYTES + 5, -1);      // empty message
        send_message(TYPE_TWO_RST + 32'd1, 16'd2, HDR_BYTES + 2 * REC_BYTES, -1);  // dropped
        send_message(TYPE_TWO_RST, 16'd3, HDR_BYTES + REC_BYTES + 10, -1);  // short message
        send_message(TYPE_ONE_RST, 16'd3, HDR_BYTES + REC_BYTES + IND_LO_POS + 1, -1);
        send_message(TYPE_TWO_RST, 16'd1, HDR_BYTES + IND_LO_POS + 1, -1);
        send_message(TYPE_ONE_RST, 16'd2, 20, -1);                 // short header
        send_message(TYPE_ONE_RST, 16'd2, 1, -1);
        send_message(TYPE_ONE_RST, 16'd2, HDR_BYTES, -1);          // ends on the count byte
        send_message(TYPE_TWO_RST, 16'd2, HDR_BYTES + 2 * REC_BYTES + 7, -1);  // extra bytes
        send_message(TYPE_ONE_RST, 16'd25, HDR_BYTES + 3 * REC_BYTES + 5, -1);
        // clamped count ending short, with the result side held off
        hold_request = 1'b1;
        send_message(TYPE_TWO_RST, 16'h7FFF, HDR_BYTES + 6 * REC_BYTES + 10, -1);

        wait_idle();
        write_types('0, '1);
        send_message('0, 16'd1, HDR_BYTES + REC_BYTES, 8'hFF);
        send_message('1, 16'd2, HDR_BYTES + 2 * REC_BYTES, -1);
        send_message(TYPE_ONE_RST, 16'd1, HDR_BYTES + REC_BYTES, -1);
        wait_idle();
        write_types(32'h5A5A_A5A5, 32'h5A5A_A5A5);
        send_message(32'h5A5A_A5A5, 16'd2, HDR_BYTES + 2 * REC_BYTES, -1);

        msg_count  = 0;
        rand_start = sent_bytes;
        while (sent_bytes - rand_start < RAND_BYTES) begin
            if (msg_count % 6 == 5)
                random_config();
            random_message();
            msg_count++;
            if (sent_bytes - rand_start >= QUIET_BYTES)
                idle_on = 1'b0;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0)
            $display("[index_broadcast_record_parser_core] OK");
        else
            $display("[index_broadcast_record_parser_core] ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/ibrp_pkg.sv
design/ibrp_parser.sv
design/ibrp_out_buf.sv
design/index_broadcast_record_parser_core.sv
tb/testbench.sv
